// ===== hdl/avcsps_pkg.sv =====
// ----------------------------------------------------------------------------
// avcsps_pkg
// Types, constants and syntax steps shared by the SPS dimension parser.
// ----------------------------------------------------------------------------
package avcsps_pkg;

  localparam int MAX_GOLOMB_ZEROS  = 16;
  localparam int HEADER_SKIP_BYTES = 5;

  localparam int GV_W   = MAX_GOLOMB_ZEROS + 1;
  localparam int CROP_W = 17;
  localparam logic [CROP_W-1:0] CROP_LIMIT = 17'h1FFFF;

  localparam logic [7:0] PROF_HIGH     = 8'd100;
  localparam logic [7:0] PROF_HIGH10   = 8'd110;
  localparam logic [7:0] PROF_HIGH422  = 8'd122;
  localparam logic [7:0] PROF_HIGH444  = 8'd244;
  localparam logic [7:0] PROF_CAVLC444 = 8'd44;
  localparam logic [7:0] PROF_SCALE_B  = 8'd83;
  localparam logic [7:0] PROF_SCALE_H  = 8'd86;
  localparam logic [7:0] PROF_MVC_H    = 8'd118;
  localparam logic [7:0] PROF_MVC_D    = 8'd183;

  typedef enum logic [5:0] {
    ST_HDR, ST_PROFILE, ST_CONSTR, ST_LEVEL, ST_SPSID, ST_CHROMA, ST_SEPPLANE,
    ST_BDLUMA, ST_BDCHROMA, ST_QPBYPASS, ST_SCALEFLAG, ST_SCALESKIP, ST_LOG2FN,
    ST_POCTYPE, ST_POCLSB, ST_DELTAFLAG, ST_OFFNONREF, ST_OFFTB, ST_CYCLEN,
    ST_CYCLEOFF, ST_MAXREF, ST_GAPS, ST_WIDTH, ST_HEIGHT, ST_FMO, ST_MBAFF,
    ST_DIRECT8, ST_CROPFLAG, ST_CROPL, ST_CROPR, ST_CROPT, ST_CROPB, ST_DONE
  } step_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EARLY = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_CROP  = 2'd3
  } status_e;

  typedef struct packed {
    step_e              step;
    logic [2:0]         hdr;
    logic [4:0]         zc;
    logic [GV_W-1:0]    gv;
    logic               suf;
    logic [3:0]         fbl;
    logic [7:0]         fa;
    logic [7:0]         prof;
    logic [7:0]         lvl;
    logic [1:0]         chroma;
    logic               fmo;
    logic [7:0]         poc;
    logic [11:0]        wm;
    logic [11:0]        hm;
    logic [CROP_W-1:0]  chs;
    logic [CROP_W-1:0]  cvs;
    logic [1:0]         err;
  } parse_t;

  typedef struct packed {
    logic [7:0]  profile_num;
    logic [7:0]  level_num;
    logic [15:0] pic_width;
    logic [15:0] pic_height;
    status_e     status;
  } result_t;

endpackage

// ===== hdl/avcsps_core.sv =====
// ----------------------------------------------------------------------------
// avcsps_core
// SPS syntax walker: eight bit steps per item and the dimension result.
// ----------------------------------------------------------------------------
module avcsps_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output avcsps_pkg::result_t  res_o
);

  function automatic logic [3:0] fixed_len(avcsps_pkg::step_e st, logic [1:0] chroma);
    logic [3:0] n;
    case (st)
      avcsps_pkg::ST_PROFILE, avcsps_pkg::ST_CONSTR, avcsps_pkg::ST_LEVEL: n = 4'd8;
      avcsps_pkg::ST_SCALESKIP: n = (chroma != 2'd3) ? 4'd8 : 4'd12;
      avcsps_pkg::ST_SEPPLANE, avcsps_pkg::ST_QPBYPASS, avcsps_pkg::ST_SCALEFLAG,
      avcsps_pkg::ST_DELTAFLAG, avcsps_pkg::ST_GAPS, avcsps_pkg::ST_FMO,
      avcsps_pkg::ST_MBAFF, avcsps_pkg::ST_DIRECT8, avcsps_pkg::ST_CROPFLAG: n = 4'd1;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  function automatic avcsps_pkg::parse_t enter_st(avcsps_pkg::parse_t s,
                                                  avcsps_pkg::step_e st);
    avcsps_pkg::parse_t r;
    r      = s;
    r.step = st;
    r.fbl  = fixed_len(st, s.chroma);
    r.fa   = '0;
    r.zc   = '0;
    r.gv   = '0;
    r.suf  = 1'b0;
    return r;
  endfunction

  function automatic avcsps_pkg::parse_t fail_st(avcsps_pkg::parse_t s);
    avcsps_pkg::parse_t r;
    r     = s;
    r.err = avcsps_pkg::STATUS_RANGE;
    return enter_st(r, avcsps_pkg::ST_DONE);
  endfunction

  function automatic avcsps_pkg::parse_t reset_st();
    avcsps_pkg::parse_t r;
    r        = '0;
    r.chroma = 2'd1;
    r.fmo    = 1'b1;
    return enter_st(r, (avcsps_pkg::HEADER_SKIP_BYTES == 0) ?
                       avcsps_pkg::ST_PROFILE : avcsps_pkg::ST_HDR);
  endfunction

  function automatic logic high_profile(logic [7:0] p);
    return p == avcsps_pkg::PROF_HIGH || p == avcsps_pkg::PROF_HIGH10 ||
           p == avcsps_pkg::PROF_HIGH422 || p == avcsps_pkg::PROF_HIGH444 ||
           p == avcsps_pkg::PROF_CAVLC444 || p == avcsps_pkg::PROF_SCALE_B ||
           p == avcsps_pkg::PROF_SCALE_H || p == avcsps_pkg::PROF_MVC_H;
  endfunction

  function automatic avcsps_pkg::parse_t finish_st(avcsps_pkg::parse_t s,
                                                   logic [avcsps_pkg::GV_W-1:0] v);
    avcsps_pkg::parse_t r;
    logic [7:0] pc;
    r  = s;
    pc = s.poc - 8'd1;
    case (s.step)
      avcsps_pkg::ST_PROFILE: begin
        r.prof = v[7:0];
        r = enter_st(r, avcsps_pkg::ST_CONSTR);
      end
      avcsps_pkg::ST_CONSTR: r = enter_st(r, avcsps_pkg::ST_LEVEL);
      avcsps_pkg::ST_LEVEL: begin
        r.lvl = v[7:0];
        r = enter_st(r, avcsps_pkg::ST_SPSID);
      end
      avcsps_pkg::ST_SPSID: begin
        if (high_profile(s.prof)) begin
          r = enter_st(r, avcsps_pkg::ST_CHROMA);
        end else begin
          r.chroma = (s.prof == avcsps_pkg::PROF_MVC_D) ? 2'd0 : 2'd1;
          r = enter_st(r, avcsps_pkg::ST_LOG2FN);
        end
      end
      avcsps_pkg::ST_CHROMA: begin
        if (v > 3) begin
          r = fail_st(r);
        end else begin
          r.chroma = v[1:0];
          r = enter_st(r, (v == 3) ? avcsps_pkg::ST_SEPPLANE : avcsps_pkg::ST_BDLUMA);
        end
      end
      avcsps_pkg::ST_SEPPLANE:  r = enter_st(r, avcsps_pkg::ST_BDLUMA);
      avcsps_pkg::ST_BDLUMA:    r = enter_st(r, avcsps_pkg::ST_BDCHROMA);
      avcsps_pkg::ST_BDCHROMA:  r = enter_st(r, avcsps_pkg::ST_QPBYPASS);
      avcsps_pkg::ST_QPBYPASS:  r = enter_st(r, avcsps_pkg::ST_SCALEFLAG);
      avcsps_pkg::ST_SCALEFLAG:
        r = enter_st(r, (v != 0) ? avcsps_pkg::ST_SCALESKIP : avcsps_pkg::ST_LOG2FN);
      avcsps_pkg::ST_SCALESKIP: r = enter_st(r, avcsps_pkg::ST_LOG2FN);
      avcsps_pkg::ST_LOG2FN:    r = enter_st(r, avcsps_pkg::ST_POCTYPE);
      avcsps_pkg::ST_POCTYPE:
        r = enter_st(r, (v == 0) ? avcsps_pkg::ST_POCLSB :
                        ((v == 1) ? avcsps_pkg::ST_DELTAFLAG : avcsps_pkg::ST_MAXREF));
      avcsps_pkg::ST_POCLSB:    r = enter_st(r, avcsps_pkg::ST_MAXREF);
      avcsps_pkg::ST_DELTAFLAG: r = enter_st(r, avcsps_pkg::ST_OFFNONREF);
      avcsps_pkg::ST_OFFNONREF: r = enter_st(r, avcsps_pkg::ST_OFFTB);
      avcsps_pkg::ST_OFFTB:     r = enter_st(r, avcsps_pkg::ST_CYCLEN);
      avcsps_pkg::ST_CYCLEN: begin
        if (v > 255) begin
          r = fail_st(r);
        end else begin
          r.poc = v[7:0];
          r = enter_st(r, (v != 0) ? avcsps_pkg::ST_CYCLEOFF : avcsps_pkg::ST_MAXREF);
        end
      end
      avcsps_pkg::ST_CYCLEOFF: begin
        r.poc = pc;
        r = enter_st(r, (pc != 8'd0) ? avcsps_pkg::ST_CYCLEOFF : avcsps_pkg::ST_MAXREF);
      end
      avcsps_pkg::ST_MAXREF: r = enter_st(r, avcsps_pkg::ST_GAPS);
      avcsps_pkg::ST_GAPS:   r = enter_st(r, avcsps_pkg::ST_WIDTH);
      avcsps_pkg::ST_WIDTH: begin
        if (v > 4095) begin
          r = fail_st(r);
        end else begin
          r.wm = v[11:0];
          r = enter_st(r, avcsps_pkg::ST_HEIGHT);
        end
      end
      avcsps_pkg::ST_HEIGHT: begin
        if (v > 4095) begin
          r = fail_st(r);
        end else begin
          r.hm = v[11:0];
          r = enter_st(r, avcsps_pkg::ST_FMO);
        end
      end
      avcsps_pkg::ST_FMO: begin
        r.fmo = v[0];
        r = enter_st(r, v[0] ? avcsps_pkg::ST_DIRECT8 : avcsps_pkg::ST_MBAFF);
      end
      avcsps_pkg::ST_MBAFF:   r = enter_st(r, avcsps_pkg::ST_DIRECT8);
      avcsps_pkg::ST_DIRECT8: r = enter_st(r, avcsps_pkg::ST_CROPFLAG);
      avcsps_pkg::ST_CROPFLAG:
        r = enter_st(r, (v != 0) ? avcsps_pkg::ST_CROPL : avcsps_pkg::ST_DONE);
      avcsps_pkg::ST_CROPL: begin
        if (v > avcsps_pkg::CROP_LIMIT) begin
          r = fail_st(r);
        end else begin
          r.chs = avcsps_pkg::CROP_W'(v);
          r = enter_st(r, avcsps_pkg::ST_CROPR);
        end
      end
      avcsps_pkg::ST_CROPR: begin
        if (v > avcsps_pkg::CROP_LIMIT - s.chs) begin
          r = fail_st(r);
        end else begin
          r.chs = s.chs + avcsps_pkg::CROP_W'(v);
          r = enter_st(r, avcsps_pkg::ST_CROPT);
        end
      end
      avcsps_pkg::ST_CROPT: begin
        if (v > avcsps_pkg::CROP_LIMIT) begin
          r = fail_st(r);
        end else begin
          r.cvs = avcsps_pkg::CROP_W'(v);
          r = enter_st(r, avcsps_pkg::ST_CROPB);
        end
      end
      avcsps_pkg::ST_CROPB: begin
        if (v > avcsps_pkg::CROP_LIMIT - s.cvs) begin
          r = fail_st(r);
        end else begin
          r.cvs = s.cvs + avcsps_pkg::CROP_W'(v);
          r = enter_st(r, avcsps_pkg::ST_DONE);
        end
      end
      default: r = enter_st(r, avcsps_pkg::ST_DONE);
    endcase
    return r;
  endfunction

  function automatic avcsps_pkg::parse_t feed_bit(avcsps_pkg::parse_t s, logic b);
    avcsps_pkg::parse_t r;
    logic [7:0] fa;
    logic [avcsps_pkg::GV_W-1:0] gv;
    r  = s;
    fa = {s.fa[6:0], b};
    gv = {s.gv[avcsps_pkg::GV_W-2:0], b};
    if (s.step == avcsps_pkg::ST_DONE || s.step == avcsps_pkg::ST_HDR) begin
      r = s;
    end else if (s.fbl != 4'd0) begin
      r.fa  = fa;
      r.fbl = s.fbl - 4'd1;
      if (s.fbl == 4'd1) r = finish_st(r, avcsps_pkg::GV_W'(fa));
    end else if (!s.suf) begin
      if (!b) begin
        if (s.zc >= 5'(avcsps_pkg::MAX_GOLOMB_ZEROS)) r = fail_st(r);
        else r.zc = s.zc + 5'd1;
      end else if (s.zc == 5'd0) begin
        r = finish_st(r, '0);
      end else begin
        r.suf = 1'b1;
        r.gv  = avcsps_pkg::GV_W'(1);
      end
    end else begin
      r.gv = gv;
      r.zc = s.zc - 5'd1;
      if (s.zc == 5'd1) r = finish_st(r, gv - avcsps_pkg::GV_W'(1));
    end
    return r;
  endfunction

  avcsps_pkg::parse_t state_q, state_d, walk;

  logic [16:0] fw;
  logic [17:0] fh, fh_base, cw, w_full;
  logic [18:0] ch, h_full;
  logic [1:0]  cy_sh;
  logic        cx_two, crop_bad, over;

  always_comb begin
    walk = state_q;
    if (state_q.step == avcsps_pkg::ST_HDR) begin
      walk.hdr = state_q.hdr + 3'd1;
      if (walk.hdr >= 3'(avcsps_pkg::HEADER_SKIP_BYTES)) begin
        walk = enter_st(walk, avcsps_pkg::ST_PROFILE);
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        walk = feed_bit(walk, byte_i[7-i]);
      end
    end
    state_d = last_i ? reset_st() : walk;
  end

  // cropped size from macroblock counts and chroma-scaled crop units
  always_comb begin
    fw      = ({5'd0, walk.wm} + 17'd1) << 4;
    fh_base = {6'd0, walk.hm} + 18'd1;
    fh      = walk.fmo ? (fh_base << 4) : (fh_base << 5);
    cx_two  = (walk.chroma == 2'd1) || (walk.chroma == 2'd2);
    if (walk.chroma == 2'd1) cy_sh = walk.fmo ? 2'd1 : 2'd2;
    else cy_sh = walk.fmo ? 2'd0 : 2'd1;
    cw = {1'b0, walk.chs} << cx_two;
    ch = {2'b0, walk.cvs} << cy_sh;
    crop_bad = 1'b0;
    if (cw > {1'b0, fw}) begin
      w_full = '0;
      crop_bad = 1'b1;
    end else begin
      w_full = {1'b0, fw} - cw;
    end
    if (ch > {1'b0, fh}) begin
      h_full = '0;
      crop_bad = 1'b1;
    end else begin
      h_full = {1'b0, fh} - ch;
    end
    over = (w_full > 18'd65535) || (h_full > 19'd65535);

    res_o.profile_num = walk.prof;
    res_o.level_num   = walk.lvl;
    res_o.pic_width   = '0;
    res_o.pic_height  = '0;
    if (walk.err != 2'd0) begin
      res_o.status = avcsps_pkg::STATUS_RANGE;
    end else if (walk.step != avcsps_pkg::ST_DONE) begin
      res_o.status = avcsps_pkg::STATUS_EARLY;
    end else begin
      res_o.pic_width  = (w_full > 18'd65535) ? 16'hFFFF : w_full[15:0];
      res_o.pic_height = (h_full > 19'd65535) ? 16'hFFFF : h_full[15:0];
      res_o.status = over ? avcsps_pkg::STATUS_RANGE :
                     (crop_bad ? avcsps_pkg::STATUS_CROP : avcsps_pkg::STATUS_OK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= reset_st();
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/avc_sps_dimension_parser_top.sv =====
// ----------------------------------------------------------------------------
// avc_sps_dimension_parser_top
// H.264 SPS parser giving profile, level and cropped luma size.
// ----------------------------------------------------------------------------
// Usage: feed one SPS buffer one byte per item on the input channel, start
// code first, with last_byte_i high on the final byte. The first header bytes
// are skipped, the rest is walked bit by bit, eight bit steps per item.
// Exactly one result item comes out per buffer, after its last byte.
// Timing: an item is taken into an input register and walked from there; for
// a last byte the result is written to the output register when that byte is
// walked, and out_valid_o rises with that write.
// Throughput: one byte per cycle while no last byte waits on a held result, as
// the bit walk between the input register and the parser state is combinational.
// Reset clears the parser to the header-skip step and empties both
// registers. While out_stall_i holds a result, non-last bytes keep flowing;
// a further last byte waits in the input register and in_stall_o rises.
// ----------------------------------------------------------------------------
module avc_sps_dimension_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  profile_num_o,
  output logic [7:0]  level_num_o,
  output logic [15:0] pic_width_o,
  output logic [15:0] pic_height_o,
  output logic [1:0]  status_o
);

  logic       in_valid_q, in_last_q, out_valid_q, fire;
  logic [7:0] in_byte_q;
  avcsps_pkg::result_t res, res_q;

  assign fire       = in_valid_q && !(in_last_q && out_valid_q && out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  avcsps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_last_q) res_q <= res;
  end

  assign out_valid_o   = out_valid_q;
  assign profile_num_o = res_q.profile_num;
  assign level_num_o   = res_q.level_num;
  assign pic_width_o   = res_q.pic_width;
  assign pic_height_o  = res_q.pic_height;
  assign status_o      = res_q.status;

  a_stall_only_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && in_last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(res_q)))
    else $error("held result lost or changed");

  a_early_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == avcsps_pkg::STATUS_EARLY)) |->
      (pic_width_o == 16'd0 && pic_height_o == 16'd0))
    else $error("early end with nonzero size");

endmodule
